// ===== src/motion_threshold_crossing_trigger_defines.svh =====
// Assertion macros used by the checker file.
`ifndef MOTION_THRESHOLD_CROSSING_TRIGGER_DEFINES_SVH
`define MOTION_THRESHOLD_CROSSING_TRIGGER_DEFINES_SVH

// Clocked assertion, switched off while reset is held.
`define MTCT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define MTCT_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== src/mtct_pkg.sv =====
package mtct_pkg;

    localparam int DATA_W   = 32;
    localparam int MODE_W   = 3;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_CHAN = 3;

    // Tolerance of the equal modes, Q16.16 (0 .. 65536).
    localparam int EQ_TOL = 0;
    localparam logic signed [DATA_W:0] EQ_TOL_Q = (DATA_W + 1)'(EQ_TOL);

    typedef enum logic [MODE_W-1:0] {
        MODE_UNSET     = 3'd0,
        MODE_ALWAYS    = 3'd1,
        MODE_RISING    = 3'd2,
        MODE_FALLING   = 3'd3,
        MODE_EQ_ONCE   = 3'd4,
        MODE_EQ_REPEAT = 3'd5
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE     = 3'd0,
        CFG_DISP_MODE  = 3'd1,
        CFG_VEL_MODE   = 3'd2,
        CFG_ACCEL_MODE = 3'd3,
        CFG_DISP_THR   = 3'd4,
        CFG_VEL_THR    = 3'd5,
        CFG_ACCEL_THR  = 3'd6
    } t_cfg_idx;

    typedef enum logic {
        FUNC_SAMPLE  = 1'b0,
        FUNC_RESTART = 1'b1
    } t_func;

    // Per-channel control handed to the decision logic.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              hist;
        logic              latch;
    } t_chan_ctl;

    // Per-channel decision returned.
    typedef struct packed {
        logic fire;
        logic latch;
    } t_chan_res;

endpackage

// ===== src/mtct_intf.sv =====
interface mtct_cfg_if;
    import mtct_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface mtct_sample_if;
    import mtct_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     func;
    logic signed [DATA_W-1:0] sample_time;
    logic signed [DATA_W-1:0] disp_in;
    logic signed [DATA_W-1:0] vel_in;
    logic signed [DATA_W-1:0] accel_in;

    modport source (output valid, output func, output sample_time, output disp_in,
                    output vel_in, output accel_in, input ready);
    modport sink   (input valid, input func, input sample_time, input disp_in,
                    input vel_in, input accel_in, output ready);
endinterface

interface mtct_result_if;
    import mtct_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] abs_time;
    logic signed [DATA_W-1:0] disp_out;
    logic signed [DATA_W-1:0] vel_out;
    logic signed [DATA_W-1:0] accel_out;
    logic                     disp_fired;
    logic                     vel_fired;
    logic                     accel_fired;

    modport source (output valid, output abs_time, output disp_out, output vel_out,
                    output accel_out, output disp_fired, output vel_fired,
                    output accel_fired, input ready);
    modport sink   (input valid, input abs_time, input disp_out, input vel_out,
                    input accel_out, input disp_fired, input vel_fired,
                    input accel_fired, output ready);
endinterface

// ===== src/mtct_channel.sv =====
module mtct_channel (
    input  logic signed [mtct_pkg::DATA_W-1:0] i_value,
    input  logic signed [mtct_pkg::DATA_W-1:0] i_prev,
    input  logic signed [mtct_pkg::DATA_W-1:0] i_thr,
    input  mtct_pkg::t_chan_ctl                i_ctl,
    output mtct_pkg::t_chan_res                o_res
);
    import mtct_pkg::*;

    logic                   v_gt, v_lt, p_gt, p_lt;
    logic                   same_side;
    logic signed [DATA_W:0] diff;
    logic                   in_tol;

    assign v_gt = i_value > i_thr;
    assign v_lt = i_value < i_thr;
    assign p_gt = i_prev > i_thr;
    assign p_lt = i_prev < i_thr;
    assign same_side = i_ctl.hist && ((v_gt && p_gt) || (v_lt && p_lt));

    // Distance to the level, one bit wider so it cannot wrap.
    assign diff   = $signed({i_value[DATA_W-1], i_value}) - $signed({i_thr[DATA_W-1], i_thr});
    assign in_tol = (diff <= EQ_TOL_Q) && (diff >= -EQ_TOL_Q);

    always_comb begin
        o_res.fire  = 1'b0;
        o_res.latch = i_ctl.latch;
        case (i_ctl.mode)
            MODE_ALWAYS: begin
                o_res.fire = 1'b1;
            end
            MODE_RISING: begin
                o_res.fire = i_ctl.hist && !same_side && !v_lt && p_lt;
            end
            MODE_FALLING: begin
                o_res.fire = i_ctl.hist && !same_side && !v_gt && p_gt;
            end
            MODE_EQ_ONCE, MODE_EQ_REPEAT: begin
                // Hold the latch while both samples sit on one side.
                if (!same_side) begin
                    if (in_tol) begin
                        o_res.fire  = (i_ctl.mode == MODE_EQ_REPEAT) || !i_ctl.latch;
                        o_res.latch = 1'b1;
                    end else begin
                        o_res.latch = 1'b0;
                    end
                end
            end
            default: begin
                o_res.fire = 1'b0;
            end
        endcase
    end

endmodule

// ===== src/motion_threshold_crossing_trigger.sv =====
// A request waits in the input register, then its result in the result register.
// Throughput: one request per cycle; the input register advances whenever the
// result register is empty or being taken, and restarts and disabled samples
// advance without waiting for it.
// Reset (i_rst_n low, synchronous): configuration, valid flags, history, latches and
// offset cleared; the data registers behind the valid flags are left as they are.
module motion_threshold_crossing_trigger (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mtct_cfg_if.sink       i_cfg,
    mtct_sample_if.sink    i_sample,
    mtct_result_if.source  o_result
);
    import mtct_pkg::*;

    // Configuration registers
    logic                     r_enable;
    logic [MODE_W-1:0]        r_mode  [NUM_CHAN];
    logic signed [DATA_W-1:0] r_thr   [NUM_CHAN];

    // Input register: one request waiting for its decision
    logic                     r_s1_valid;
    logic                     r_s1_func;
    logic signed [DATA_W-1:0] r_s1_time;
    logic signed [DATA_W-1:0] r_s1_val [NUM_CHAN];

    // Trigger state carried from sample to sample
    logic                     r_hist;
    logic signed [DATA_W-1:0] r_prev  [NUM_CHAN];
    logic [NUM_CHAN-1:0]      r_latch;
    logic signed [DATA_W-1:0] r_offset;

    // Result register
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_time;
    logic signed [DATA_W-1:0] r_out_val [NUM_CHAN];
    logic [NUM_CHAN-1:0]      r_out_fired;

    logic                     s1_drop;
    logic                     s1_go;
    logic                     s1_emit;
    logic                     in_acc;
    t_chan_res                chan_res [NUM_CHAN];
    logic [NUM_CHAN-1:0]      n_latch;
    logic [NUM_CHAN-1:0]      n_fired;

    // Configuration is always taken at once
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            for (int c = 0; c < NUM_CHAN; c++) begin
                r_mode[c] <= MODE_UNSET;
                r_thr[c]  <= '0;
            end
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_ENABLE:     r_enable  <= i_cfg.data[0];
                CFG_DISP_MODE:  r_mode[0] <= i_cfg.data[MODE_W-1:0];
                CFG_VEL_MODE:   r_mode[1] <= i_cfg.data[MODE_W-1:0];
                CFG_ACCEL_MODE: r_mode[2] <= i_cfg.data[MODE_W-1:0];
                CFG_DISP_THR:   r_thr[0]  <= $signed(i_cfg.data);
                CFG_VEL_THR:    r_thr[1]  <= $signed(i_cfg.data);
                CFG_ACCEL_THR:  r_thr[2]  <= $signed(i_cfg.data);
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    // A restart or a disabled sample leaves no result, so it never waits
    assign s1_drop  = (r_s1_func == FUNC_RESTART) || !r_enable;
    assign s1_go    = r_s1_valid && (s1_drop || !r_out_valid || o_result.ready);
    assign s1_emit  = s1_go && !s1_drop;

    assign i_sample.ready = !r_s1_valid || s1_go;
    assign in_acc         = i_sample.valid && i_sample.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_func   <= i_sample.func;
            r_s1_time   <= i_sample.sample_time;
            r_s1_val[0] <= i_sample.disp_in;
            r_s1_val[1] <= i_sample.vel_in;
            r_s1_val[2] <= i_sample.accel_in;
        end
    end

    // One decision unit per channel, all working on the same request
    for (genvar gc = 0; gc < NUM_CHAN; gc++) begin : g_chan
        t_chan_ctl ctl;

        assign ctl.mode  = r_mode[gc];
        assign ctl.hist  = r_hist;
        assign ctl.latch = r_latch[gc];

        mtct_channel u_chan (
            .i_value (r_s1_val[gc]),
            .i_prev  (r_prev[gc]),
            .i_thr   (r_thr[gc]),
            .i_ctl   (ctl),
            .o_res   (chan_res[gc])
        );

        assign n_latch[gc] = chan_res[gc].latch;
        assign n_fired[gc] = chan_res[gc].fire;
    end

    // Advance the trigger state as the request leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist   <= 1'b0;
            r_latch  <= '0;
            r_offset <= '0;
            for (int c = 0; c < NUM_CHAN; c++) begin
                r_prev[c] <= '0;
            end
        end else if (s1_go) begin
            if (r_s1_func == FUNC_RESTART) begin
                // Restart: load the offset, forget the history, keep the latches
                r_offset <= r_s1_time;
                r_hist   <= 1'b0;
                for (int c = 0; c < NUM_CHAN; c++) begin
                    r_prev[c] <= '0;
                end
            end else if (r_enable) begin
                r_hist  <= 1'b1;
                r_latch <= n_latch;
                for (int c = 0; c < NUM_CHAN; c++) begin
                    r_prev[c] <= r_s1_val[c];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_emit) begin
            r_out_time  <= r_s1_time + r_offset;
            r_out_fired <= n_fired;
            for (int c = 0; c < NUM_CHAN; c++) begin
                r_out_val[c] <= r_s1_val[c];
            end
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.abs_time    = r_out_time;
    assign o_result.disp_out    = r_out_val[0];
    assign o_result.vel_out     = r_out_val[1];
    assign o_result.accel_out   = r_out_val[2];
    assign o_result.disp_fired  = r_out_fired[0];
    assign o_result.vel_fired   = r_out_fired[1];
    assign o_result.accel_fired = r_out_fired[2];

endmodule

// ===== src/mtct_checker.sv =====
`include "motion_threshold_crossing_trigger_defines.svh"

module mtct_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_cfg_valid,
    input logic                                i_cfg_ready,
    input logic [mtct_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input logic [mtct_pkg::DATA_W-1:0]         i_cfg_data,
    input logic                                i_s_ready,
    input logic                                i_o_valid,
    input logic                                i_o_ready,
    input logic signed [mtct_pkg::DATA_W-1:0]  i_o_time,
    input logic signed [mtct_pkg::DATA_W-1:0]  i_o_disp
);
    import mtct_pkg::*;

    logic r_enable;

    // Track the enable register from the configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (i_cfg_valid && i_cfg_ready && i_cfg_index == CFG_ENABLE) begin
            r_enable <= i_cfg_data[0];
        end
    end

    `MTCT_ASSERT(a_stall_hold, i_o_valid && !i_o_ready |=> i_o_valid && $stable(i_o_time) && $stable(i_o_disp), "result changed while stalled")
    `MTCT_ASSERT_RST(a_reset_empty, !i_rst_n |=> !i_o_valid, "result valid after reset")
    `MTCT_ASSERT(a_ready_when_free, !i_o_valid |-> i_s_ready, "input blocked with empty result register")
    `MTCT_ASSERT(a_result_needs_enable, $rose(i_o_valid) |-> r_enable, "result while disabled")

endmodule

bind motion_threshold_crossing_trigger mtct_checker u_mtct_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_valid (i_cfg.valid),
    .i_cfg_ready (i_cfg.ready),
    .i_cfg_index (i_cfg.index),
    .i_cfg_data  (i_cfg.data),
    .i_s_ready   (i_sample.ready),
    .i_o_valid   (o_result.valid),
    .i_o_ready   (o_result.ready),
    .i_o_time    (o_result.abs_time),
    .i_o_disp    (o_result.disp_out)
);
